>>> src/sorted_key_index_table_defines.svh
// Assertion macros for the sorted key index table.
`ifndef SORTED_KEY_INDEX_TABLE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property holds at every edge outside reset.
`define SKIT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("skit: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SKIT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skit: assertion failed");

`else

`define SKIT_ASSERT(lbl, clk, rst, prop)
`define SKIT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/skit_pkg.sv
package skit_pkg;

   localparam int KEY_W = 32;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_MISS = 2'd2,
      STAT_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_HIT_RD,
      S_HIT_CMP,
      S_SHIFT,
      S_STORE
   } state_type;

endpackage

>>> src/sorted_key_index_table.sv
// Sorted key index table. Holds up to TABLE_DEPTH (key, block number) pairs in
// ascending key order in a single-port-read, single-port-write RAM. A word is
// taken when start is high and busy is low; busy then stays high until the
// result strobe. Each word gives exactly one result, shown on the rsp_ ports
// for one cycle with rsp_strobe high; the receiver cannot stall it, so it must
// capture the result in that cycle. A new word may be started in the strobe
// cycle. Timing is set by the RAM's one read per cycle and the key comparators:
// the binary search reads and then compares on each probe and closes once its
// window is empty, with at most floor(log2(entries))+1 probes (none when the
// table is empty), and the hit check reads and compares once more. The result
// of a lookup or a refused insert is registered and shown in the cycle after
// the last busy cycle. A successful insert then moves every entry from the
// insert position up by one, one entry per cycle, then drains the last read
// and stores the new pair; the worst case is 1023 entries with the new key
// below all the others. No clearing pass is needed after reset: entries at or
// above the entry count are never read.
`include "sorted_key_index_table_defines.svh"

module sorted_key_index_table #(
   parameter int TABLE_DEPTH        = 1024,
   parameter int BLOCK_NUMBER_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic [skit_pkg::KEY_W-1:0]            req_key,
   input  logic [BLOCK_NUMBER_WIDTH-1:0]         req_block_in,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]      rsp_position,
   output logic [BLOCK_NUMBER_WIDTH-1:0]         rsp_block_out,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]      rsp_entry_count
);
   import skit_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   state_type state_ff, state_in;

   // latched request word
   op_type                        op_ff, op_in;
   logic [KEY_W-1:0]              key_ff, key_in;
   logic [BLOCK_NUMBER_WIDTH-1:0] blk_ff, blk_in;

   // search window; lo ends as the lower bound
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // shift pointer and the one read in flight
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;

   logic                          strobe_ff, strobe_in;
   status_type                    status_ff, status_in;
   logic [CNT_W-1:0]              pos_ff, pos_in;
   logic [BLOCK_NUMBER_WIDTH-1:0] blk_out_ff, blk_out_in;

   // RAM port
   logic                          wr_en, rd_en;
   logic [ADDR_W-1:0]             wr_addr, rd_addr;
   logic [KEY_W-1:0]              wr_key, rd_key;
   logic [BLOCK_NUMBER_WIDTH-1:0] wr_block, rd_block;

   logic [CNT_W-1:0] mid_calc;
   logic [CNT_W-1:0] idx_m1;
   logic             key_below;
   logic             window_open;
   logic             hit;

   // the key comparator: stored key against the request key
   assign key_below   = rd_key < key_ff;
   assign window_open = lo_ff < hi_ff;
   assign mid_calc    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_m1      = idx_ff - 1'b1;
   assign hit         = (lo_ff < count_ff) && (rd_key == key_ff);

   skit_ram #(
      .DEPTH   (TABLE_DEPTH),
      .BLOCK_W (BLOCK_NUMBER_WIDTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_block (wr_block),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_block (rd_block)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            state_in = window_open ? S_SRCH_CMP : S_HIT_RD;
         end
         S_SRCH_CMP: state_in = S_SRCH_RD;
         S_HIT_RD:   state_in = S_HIT_CMP;
         S_HIT_CMP: begin
            if (op_ff == OP_INSERT && !hit && count_ff != FULL_COUNT) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (idx_ff <= lo_ff) state_in = S_STORE;
         end
         S_STORE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      blk_in       = blk_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      pos_in       = pos_ff;
      blk_out_in   = blk_out_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_key       = rd_key;
      wr_block     = rd_block;
      rd_en        = 1'b0;
      rd_addr      = mid_calc[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_operation);
               key_in = req_key;
               blk_in = req_block_in;
               lo_in  = '0;
               hi_in  = count_ff;
            end
         end
         S_SRCH_RD: begin
            if (window_open) begin
               rd_en  = 1'b1;
               mid_in = mid_calc;
            end
         end
         S_SRCH_CMP: begin
            if (key_below) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
         end
         S_HIT_RD: begin
            rd_en   = lo_ff < count_ff;
            rd_addr = lo_ff[ADDR_W-1:0];
         end
         S_HIT_CMP: begin
            pos_in     = lo_ff;
            blk_out_in = '0;
            idx_in     = count_ff;
            if (op_ff == OP_LOOKUP) begin
               strobe_in = 1'b1;
               if (hit) begin
                  status_in  = STAT_OK;
                  blk_out_in = rd_block;
               end else begin
                  status_in = STAT_MISS;
               end
            end else if (hit) begin
               strobe_in  = 1'b1;
               status_in  = STAT_DUP;
               blk_out_in = rd_block;
            end else if (count_ff == FULL_COUNT) begin
               strobe_in = 1'b1;
               status_in = STAT_FULL;
            end
         end
         S_SHIFT: begin
            // write back last cycle's read one slot higher
            wr_en = pend_ff;
            if (idx_ff > lo_ff) begin
               rd_en        = 1'b1;
               rd_addr      = idx_m1[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[ADDR_W-1:0];
               idx_in       = idx_m1;
            end
         end
         S_STORE: begin
            wr_en      = 1'b1;
            wr_addr    = lo_ff[ADDR_W-1:0];
            wr_key     = key_ff;
            wr_block   = blk_ff;
            count_in   = count_ff + 1'b1;
            strobe_in  = 1'b1;
            status_in  = STAT_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      blk_ff       <= blk_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
      blk_out_ff   <= blk_out_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_ff;
   assign rsp_block_out   = blk_out_ff;
   assign rsp_entry_count = count_ff;

   // a result always closes its word, leaving the block free
   `SKIT_ASSERT(a_strobe_idle, clock, reset, !rsp_strobe || !busy)
   // a taken word keeps the block busy until its result
   `SKIT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy && !rsp_strobe)
   // entry count never passes the table size
   `SKIT_ASSERT(a_count_max, clock, reset, count_ff <= FULL_COUNT)
   // count moves only with a successful insert result
   `SKIT_ASSERT(a_count_ok, clock, reset,
                $stable(count_ff) || (rsp_strobe && rsp_status == STAT_OK))
   // no RAM write outside an insert
   `SKIT_ASSERT(a_wr_insert, clock, reset, !wr_en || op_ff == OP_INSERT)

endmodule

>>> src/skit_ram.sv
// Key and block-number store: one write port, one registered read port.
module skit_ram #(
   parameter int DEPTH   = 2,
   parameter int BLOCK_W = 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [skit_pkg::KEY_W-1:0]   wr_key,
   input  logic [BLOCK_W-1:0]           wr_block,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [skit_pkg::KEY_W-1:0]   rd_key,
   output logic [BLOCK_W-1:0]           rd_block
);
   import skit_pkg::*;

   logic [KEY_W-1:0]   key_mem_ff   [DEPTH];
   logic [BLOCK_W-1:0] block_mem_ff [DEPTH];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [BLOCK_W-1:0] rd_block_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr]   <= wr_key;
         block_mem_ff[wr_addr] <= wr_block;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= key_mem_ff[rd_addr];
         rd_block_ff <= block_mem_ff[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_block = rd_block_ff;

endmodule
